// ===== rtl/elg_pkg.sv =====
package elg_pkg;

	localparam int MOD_BITS = 32;
	localparam int CNT_W    = $clog2(MOD_BITS);
	localparam int IDX_W    = 3;

	localparam logic [IDX_W-1:0] REG_MODULUS   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GENERATOR = 3'd1;
	localparam logic [IDX_W-1:0] REG_PUBLIC    = 3'd2;
	localparam logic [IDX_W-1:0] REG_PRIVATE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_EPHEMERAL = 3'd4;

	typedef logic [MOD_BITS-1:0] word_t;

	typedef struct packed {
		word_t p;
		word_t g;
		word_t d;
		word_t c;
		word_t k;
	} keys_t;

	typedef struct packed {
		logic  ready;
		word_t r;
		word_t em;
		word_t dm;
	} mask_t;

	// one shift-add step: (2*acc + b_i*a) mod m, with acc and a below m
	function automatic word_t mod_step(word_t acc, word_t a, logic b_i, word_t m);
		logic [MOD_BITS:0] d;
		logic [MOD_BITS:0] s;
		d = {acc, 1'b0};
		if (d >= {1'b0, m})
			d = d - {1'b0, m};
		s = d + (b_i ? {1'b0, a} : '0);
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[MOD_BITS-1:0];
	endfunction

endpackage

// ===== rtl/elgamal_modular_crypt_top.sv =====
// channel | direction | handshake            | payload
// cmd     | in        | cmd_valid/cmd_stall  | op, value
// rsp     | out       | rsp_valid/rsp_stall  | value_out, ephemeral_public
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per cycle once the masks are cached and no result is stalled; items pass
// through the bit-serial multiply pipeline, one stage per bit of value.
// First item after reset or a register write waits for the mask build on one
// shared bit-serial multiplier.
// Reset clears the keys to their defaults and drops the cached masks.
// A stalled result freezes the whole pipeline and stalls cmd.
module elgamal_modular_crypt_top
	import elg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  logic             op,
	input  word_t            value,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output word_t            value_out,
	output word_t            ephemeral_public,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  word_t            cfg_data
);

	keys_t keys_q;
	mask_t mk;
	logic  en;
	logic  cfg_wr;
	logic  cfg_clr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_clr   = cfg_wr && (cfg_index <= REG_EPHEMERAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q.p <= word_t'(3);
			keys_q.g <= word_t'(2);
			keys_q.d <= word_t'(1);
			keys_q.c <= word_t'(1);
			keys_q.k <= word_t'(1);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_MODULUS:   keys_q.p <= cfg_data;
				REG_GENERATOR: keys_q.g <= cfg_data;
				REG_PUBLIC:    keys_q.d <= cfg_data;
				REG_PRIVATE:   keys_q.c <= cfg_data;
				REG_EPHEMERAL: keys_q.k <= cfg_data;
				default: ;
			endcase
		end
	end

	elg_maskgen u_maskgen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd_valid),
		.clr    (cfg_clr),
		.keys   (keys_q),
		.mask   (mk)
	);

	assign en        = !(rsp_valid && rsp_stall);
	assign cmd_stall = !en || !mk.ready;

	elg_mulpipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (cmd_valid && !cmd_stall),
		.value   (value),
		.mask    (op ? mk.dm : mk.em),
		.m       (keys_q.p),
		.out_v   (rsp_valid),
		.out_acc (value_out)
	);

	assign ephemeral_public = mk.r;

`ifndef SYNTHESIS
	a_accept_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |-> mk.ready) else $error("item taken without masks");
	a_cfg_drops: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_clr |=> !mk.ready) else $error("masks kept after register write");
	a_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && keys_q.p == '0) |-> value_out == '0) else $error("nonzero result at p=0");
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && keys_q.p != '0) |-> value_out < keys_q.p) else $error("result not reduced");
`endif

endmodule

// ===== rtl/elg_mulu.sv =====
module elg_mulu
	import elg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t a,
	input  word_t b,
	input  word_t m,
	output logic  done,
	output word_t res
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            acc_q;
	word_t            a_q;
	word_t            b_q;
	word_t            m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MOD_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= mod_step(acc_q, a_q, b_q[cnt_q], m_q);
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

// ===== rtl/elg_maskgen.sv =====
module elg_maskgen
	import elg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req,
	input  logic  clr,
	input  keys_t keys,
	output mask_t mask
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REM  = 3'd1;
	localparam logic [2:0] ST_BASE = 3'd2;
	localparam logic [2:0] ST_LOOP = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_SQR  = 3'd5;

	localparam logic [1:0] PH_R   = 2'd0;
	localparam logic [1:0] PH_ENC = 2'd1;
	localparam logic [1:0] PH_DEC = 2'd2;

	logic [2:0] st_q, st_d;
	logic [1:0] phase_q, phase_d;
	logic       valid_q, valid_d;
	word_t      base_q, base_d, res_q, res_d, ex_q, ex_d, ex3_q, ex3_d;
	word_t      r_q, r_d, em_q, em_d, dm_q, dm_d;
	word_t      pm1, one;
	logic       u_start, u_done;
	word_t      u_a, u_b, u_m, u_res;

	assign pm1 = keys.p - 1'b1;
	assign one = (keys.p == word_t'(1)) ? '0 : word_t'(1);

	elg_mulu u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start),
		.a      (u_a),
		.b      (u_b),
		.m      (u_m),
		.done   (u_done),
		.res    (u_res)
	);

	always_comb begin
		st_d    = st_q;
		phase_d = phase_q;
		valid_d = valid_q;
		base_d  = base_q;
		res_d   = res_q;
		ex_d    = ex_q;
		ex3_d   = ex3_q;
		r_d     = r_q;
		em_d    = em_q;
		dm_d    = dm_q;
		u_start = 1'b0;
		u_a     = one;
		u_b     = keys.g;
		u_m     = keys.p;
		unique case (st_q)
			ST_IDLE: begin
				if (req && !valid_q) begin
					if (keys.p == '0) begin
						r_d     = '0;
						em_d    = '0;
						dm_d    = '0;
						valid_d = 1'b1;
					end else if (pm1 == '0) begin
						ex3_d   = '0;
						phase_d = PH_R;
						u_start = 1'b1;
						st_d    = ST_BASE;
					end else begin
						u_start = 1'b1;
						u_a     = (pm1 == word_t'(1)) ? '0 : word_t'(1);
						u_b     = keys.c;
						u_m     = pm1;
						st_d    = ST_REM;
					end
				end
			end
			ST_REM: begin
				u_m = pm1;
				if (u_done) begin
					ex3_d   = pm1 - u_res;
					phase_d = PH_R;
					u_start = 1'b1;
					u_m     = keys.p;
					st_d    = ST_BASE;
				end
			end
			ST_BASE: begin
				if (u_done) begin
					base_d = u_res;
					res_d  = one;
					ex_d   = (phase_q == PH_DEC) ? ex3_q : keys.k;
					st_d   = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (ex_q == '0) begin
					case (phase_q)
						PH_R:    r_d  = res_q;
						PH_ENC:  em_d = res_q;
						default: dm_d = res_q;
					endcase
					if (phase_q == PH_DEC) begin
						valid_d = 1'b1;
						st_d    = ST_IDLE;
					end else begin
						phase_d = phase_q + 2'd1;
						u_start = 1'b1;
						u_b     = (phase_q == PH_R) ? keys.d : r_q;
						st_d    = ST_BASE;
					end
				end else begin
					u_start = 1'b1;
					u_a     = base_q;
					u_b     = ex_q[0] ? res_q : base_q;
					st_d    = ex_q[0] ? ST_MUL : ST_SQR;
				end
			end
			ST_MUL: begin
				if (u_done) begin
					res_d   = u_res;
					u_start = 1'b1;
					u_a     = base_q;
					u_b     = base_q;
					st_d    = ST_SQR;
				end
			end
			ST_SQR: begin
				if (u_done) begin
					base_d = u_res;
					ex_d   = ex_q >> 1;
					st_d   = ST_LOOP;
				end
			end
			default: st_d = ST_IDLE;
		endcase
		if (clr)
			valid_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= PH_R;
			valid_q <= 1'b0;
			r_q     <= '0;
			em_q    <= '0;
			dm_q    <= '0;
		end else begin
			st_q    <= st_d;
			phase_q <= phase_d;
			valid_q <= valid_d;
			r_q     <= r_d;
			em_q    <= em_d;
			dm_q    <= dm_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q <= base_d;
		res_q  <= res_d;
		ex_q   <= ex_d;
		ex3_q  <= ex3_d;
	end

	assign mask.ready = valid_q;
	assign mask.r     = r_q;
	assign mask.em    = em_q;
	assign mask.dm    = dm_q;

endmodule

// ===== rtl/elg_mulpipe.sv =====
module elg_mulpipe
	import elg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_v,
	input  word_t value,
	input  word_t mask,
	input  word_t m,
	output logic  out_v,
	output word_t out_acc
);

	logic  v_s    [MOD_BITS];
	word_t acc_s  [MOD_BITS];
	word_t val_s  [MOD_BITS];
	word_t mask_s [MOD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MOD_BITS; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
			for (int k = 1; k < MOD_BITS; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	// stage k folds in value bit MOD_BITS-1-k, most significant first
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0]  <= mod_step('0, mask, value[MOD_BITS-1], m);
			val_s[0]  <= value;
			mask_s[0] <= mask;
			for (int k = 1; k < MOD_BITS; k++) begin
				acc_s[k]  <= mod_step(acc_s[k-1], mask_s[k-1], val_s[k-1][MOD_BITS-1-k], m);
				val_s[k]  <= val_s[k-1];
				mask_s[k] <= mask_s[k-1];
			end
		end
	end

	assign out_v   = v_s[MOD_BITS-1];
	assign out_acc = acc_s[MOD_BITS-1];

endmodule
